// File: rtl/core/svac_pkg.sv
// Shared types, constants and table helpers for the SVPWM compare generator.
`timescale 1ns / 1ps

package svac_pkg;

  // Modulation index limit, 2/sqrt(3) in Q1.14
  localparam logic [14:0] MOD_LIMIT  = 15'd18919;
  // One third of a turn in angle counts
  localparam logic [15:0] THIRD_TURN = 16'd21845;

  // Q30 constants for building the sine table
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint TAY_A1  = 64'sd1686629713;
  localparam longint TAY_A3  = 64'sd693598668;
  localparam longint TAY_A5  = 64'sd85569305;
  localparam longint TAY_A7  = 64'sd5026994;
  localparam longint TAY_A9  = 64'sd172273;

  // Duty at full scale, 2^31
  localparam logic [31:0] DUTY_FULL = 32'h8000_0000;

  typedef logic signed [15:0] sine_t;   // Q1.15
  typedef logic signed [30:0] phase_t;  // Q2.29 product of index and sine
  typedef logic [31:0]        duty_t;   // Q30 duty, 0 to 2^31

  // Stage advance strobes for the zero-sequence datapath
  typedef struct packed {
    logic prod;
    logic minmax;
    logic duty;
  } svac_adv_t;

  // (a * b) >> 30 with b >= 0, truncated toward zero
  function automatic longint mul_q30(input longint a, input longint b);
    longint mag;
    longint res;
    mag = (a < 0) ? -a : a;
    res = (mag * b) >>> 30;
    return (a < 0) ? -res : res;
  endfunction

endpackage

// File: rtl/core/svac_sine_rom.sv
// Full-wave sine table from a quarter-wave Taylor series, built at elaboration, with registered read.
`timescale 1ns / 1ps

module svac_sine_rom import svac_pkg::*; #(
  parameter int TableDepth = 1024,
  parameter int AddrWidth  = 10
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [AddrWidth-1:0] addr_i,
  output sine_t                data_o
);

  typedef logic [15:0] rom_t [TableDepth];

  function automatic logic [15:0] sine_entry(input int k);
    longint q;
    longint r;
    longint x;
    longint x2;
    longint p;
    longint y;
    longint s;
    q = (longint'(4 * k)) / TableDepth;
    r = longint'(4 * k) - q * TableDepth;
    x = (r <<< 30) / TableDepth;
    if (q[0]) begin
      x = Q30_ONE - x;
    end
    x2 = (x * x) >>> 30;
    p = TAY_A9;
    p = -TAY_A7 + mul_q30(p, x2);
    p = TAY_A5 + mul_q30(p, x2);
    p = -TAY_A3 + mul_q30(p, x2);
    p = TAY_A1 + mul_q30(p, x2);
    y = mul_q30(p, x);
    if (y < 0) begin
      y = 0;
    end
    s = (y + 16384) >>> 15;
    if (s > 32767) begin
      s = 32767;
    end
    if (q >= 2) begin
      s = -s;
    end
    return s[15:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t tbl;
    for (int k = 0; k < TableDepth; k++) begin
      tbl[k] = sine_entry(k);
    end
    return tbl;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [15:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= SineRom[addr_i];
    end
  end

  assign data_o = sine_t'(data_q);

endmodule

// File: rtl/core/svac_zero_seq.sv
// Index scaling, min-max zero-sequence injection and duty clamp, three stages.
`timescale 1ns / 1ps

module svac_zero_seq import svac_pkg::*; (
  input  logic        clk_i,
  input  svac_adv_t   adv_i,
  input  logic [14:0] mod_index_i,
  input  sine_t       sine_u_i,
  input  sine_t       sine_v_i,
  input  sine_t       sine_w_i,
  output duty_t       duty_u_o,
  output duty_t       duty_v_o,
  output duty_t       duty_w_o
);

  logic signed [31:0] full_u, full_v, full_w;
  phase_t pu_q, pv_q, pw_q;
  phase_t pu2_q, pv2_q, pw2_q;
  phase_t mx_d, mn_d, mx_q, mn_q;
  duty_t  du_d, dv_d, dw_d;
  duty_t  du_q, dv_q, dw_q;

  // Stage: scale each sine by the index
  assign full_u = 32'($signed({1'b0, mod_index_i})) * 32'(sine_u_i);
  assign full_v = 32'($signed({1'b0, mod_index_i})) * 32'(sine_v_i);
  assign full_w = 32'($signed({1'b0, mod_index_i})) * 32'(sine_w_i);

  always_ff @(posedge clk_i) begin
    if (adv_i.prod) begin
      pu_q <= full_u[30:0];
      pv_q <= full_v[30:0];
      pw_q <= full_w[30:0];
    end
  end

  // Stage: largest and smallest phase
  always_comb begin
    mx_d = pu_q;
    if (pv_q > mx_d) mx_d = pv_q;
    if (pw_q > mx_d) mx_d = pw_q;
    mn_d = pu_q;
    if (pv_q < mn_d) mn_d = pv_q;
    if (pw_q < mn_d) mn_d = pw_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.minmax) begin
      pu2_q <= pu_q;
      pv2_q <= pv_q;
      pw2_q <= pw_q;
      mx_q  <= mx_d;
      mn_q  <= mn_d;
    end
  end

  // Stage: duty = 1 + 2p - max - min in Q30, saturated to [0, 2^31]
  function automatic duty_t to_duty(input phase_t p, input phase_t mx, input phase_t mn);
    logic signed [33:0] sum;
    sum = 34'sd1073741824 + (34'(p) <<< 1) - 34'(mx) - 34'(mn);
    if (sum < 0) begin
      return '0;
    end else if (sum > 34'sd2147483648) begin
      return DUTY_FULL;
    end
    return sum[31:0];
  endfunction

  assign du_d = to_duty(pu2_q, mx_q, mn_q);
  assign dv_d = to_duty(pv2_q, mx_q, mn_q);
  assign dw_d = to_duty(pw2_q, mx_q, mn_q);

  always_ff @(posedge clk_i) begin
    if (adv_i.duty) begin
      du_q <= du_d;
      dv_q <= dv_d;
      dw_q <= dw_d;
    end
  end

  assign duty_u_o = du_q;
  assign duty_v_o = dv_q;
  assign duty_w_o = dw_q;

endmodule

// File: rtl/core/svac_compare.sv
// Maps one Q30 duty to a timer compare value, floor(period * duty / 2^31).
`timescale 1ns / 1ps

module svac_compare import svac_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  duty_t       duty_i,
  input  logic [15:0] period_i,
  output logic [15:0] compare_o
);

  logic [47:0] prod;
  logic [15:0] compare_q;

  assign prod = 48'(duty_i) * 48'(period_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      compare_q <= prod[46:31];
    end
  end

  assign compare_o = compare_q;

endmodule

// File: rtl/core/svpwm_angle_to_compare_top.sv
// Top level of the SVPWM compare generator with min-max zero-sequence injection.
`timescale 1ns / 1ps

// Takes an electrical angle (65536 counts per turn) and a Q1.14 modulation
// index, clamps the index to 2/sqrt(3) and returns the three phase compare
// values in 0..period_count plus a flag that shows the clamp. One transfer is
// accepted every cycle while in_stall_o is low; a result passes through the six
// register stages of the pipeline (address, sine table read, index multiply,
// min/max, duty, period multiply), the first of which loads at the accepting
// edge. A held output stalls only as many stages as are full, so bubbles close
// up. The sine table is a constant ROM of SINE_TABLE_DEPTH entries, one copy per
// phase, built at elaboration.
// Write period_count only while no transfer is in flight.
module svpwm_angle_to_compare_top import svac_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] angle_i,
  input  logic [14:0] mod_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] compare_u_o,
  output logic [15:0] compare_v_o,
  output logic [15:0] compare_w_o,
  output logic        index_limited_o
);

  localparam int AW = $clog2(SINE_TABLE_DEPTH);
  localparam int PW = 16 + AW;

  logic [15:0] period_q;

  // Valid bit per stage and the ready chain from the output backward
  logic [5:0] vld_q;
  logic [5:0] rdy;

  logic [15:0] ang_v, ang_w;
  logic [PW-1:0] prod_u, prod_v, prod_w;
  logic [AW-1:0] addr_u_q, addr_v_q, addr_w_q;
  logic [14:0] mod_d;
  logic        lim_d;
  logic [14:0] mod1_q, mod2_q;
  logic [5:0]  lim_q;

  sine_t     sine_u, sine_v, sine_w;
  duty_t     duty_u, duty_v, duty_w;
  svac_adv_t adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    rdy[5] = !vld_q[5] || !out_stall_i;
    for (int k = 4; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < 6; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Stage 1: table addresses and index clamp
  assign ang_v  = angle_i - THIRD_TURN;
  assign ang_w  = angle_i + THIRD_TURN;
  assign prod_u = PW'(angle_i) * PW'(SINE_TABLE_DEPTH);
  assign prod_v = PW'(ang_v) * PW'(SINE_TABLE_DEPTH);
  assign prod_w = PW'(ang_w) * PW'(SINE_TABLE_DEPTH);
  assign lim_d  = mod_index_i > MOD_LIMIT;
  assign mod_d  = lim_d ? MOD_LIMIT : mod_index_i;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      addr_u_q <= prod_u[16 +: AW];
      addr_v_q <= prod_v[16 +: AW];
      addr_w_q <= prod_w[16 +: AW];
      mod1_q   <= mod_d;
      lim_q[0] <= lim_d;
    end
    if (rdy[1]) begin
      mod2_q   <= mod1_q;
      lim_q[1] <= lim_q[0];
    end
    for (int k = 2; k < 6; k++) begin
      if (rdy[k]) lim_q[k] <= lim_q[k-1];
    end
  end

  // Stage 2: table reads
  svac_sine_rom #(.TableDepth(SINE_TABLE_DEPTH), .AddrWidth(AW)) u_rom_u (
    .clk_i  (clk_i),
    .en_i   (rdy[1]),
    .addr_i (addr_u_q),
    .data_o (sine_u)
  );

  svac_sine_rom #(.TableDepth(SINE_TABLE_DEPTH), .AddrWidth(AW)) u_rom_v (
    .clk_i  (clk_i),
    .en_i   (rdy[1]),
    .addr_i (addr_v_q),
    .data_o (sine_v)
  );

  svac_sine_rom #(.TableDepth(SINE_TABLE_DEPTH), .AddrWidth(AW)) u_rom_w (
    .clk_i  (clk_i),
    .en_i   (rdy[1]),
    .addr_i (addr_w_q),
    .data_o (sine_w)
  );

  // Stages 3 to 5: scale, min/max, duty
  assign adv.prod   = rdy[2];
  assign adv.minmax = rdy[3];
  assign adv.duty   = rdy[4];

  svac_zero_seq u_zero_seq (
    .clk_i       (clk_i),
    .adv_i       (adv),
    .mod_index_i (mod2_q),
    .sine_u_i    (sine_u),
    .sine_v_i    (sine_v),
    .sine_w_i    (sine_w),
    .duty_u_o    (duty_u),
    .duty_v_o    (duty_v),
    .duty_w_o    (duty_w)
  );

  // Stage 6: scale by the period into the output register
  svac_compare u_cmp_u (
    .clk_i     (clk_i),
    .en_i      (rdy[5]),
    .duty_i    (duty_u),
    .period_i  (period_q),
    .compare_o (compare_u_o)
  );

  svac_compare u_cmp_v (
    .clk_i     (clk_i),
    .en_i      (rdy[5]),
    .duty_i    (duty_v),
    .period_i  (period_q),
    .compare_o (compare_v_o)
  );

  svac_compare u_cmp_w (
    .clk_i     (clk_i),
    .en_i      (rdy[5]),
    .duty_i    (duty_w),
    .period_i  (period_q),
    .compare_o (compare_w_o)
  );

  assign out_valid_o     = vld_q[5];
  assign index_limited_o = lim_q[5];

endmodule

// File: sim/tb.sv
// Testbench for the SVPWM compare generator: directed table, random transfers, predictor check.
`timescale 1ns / 1ps

module tb;

  localparam int      ROM_DEPTH   = 1024;
  localparam int      HALF_PERIOD = 4;
  localparam int      WATCH_LIMIT = 4000;
  localparam int      LONG_HOLD   = 300;
  localparam int      DRAIN_WAIT  = 10;
  localparam int      PHASE_ITEMS = 225;
  localparam int      INDEX_CEIL  = 18919;
  localparam int      THIRD       = 21845;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint TAY1        = 64'sd1686629713;
  localparam longint TAY3        = 64'sd693598668;
  localparam longint TAY5        = 64'sd85569305;
  localparam longint TAY7        = 64'sd5026994;
  localparam longint TAY9        = 64'sd172273;

  typedef struct packed {
    logic [15:0] u;
    logic [15:0] v;
    logic [15:0] w;
    logic        lim;
  } compare_set_t;

  typedef struct packed {
    logic [15:0]  ang;
    logic [14:0]  mi;
    logic [15:0]  per;
    logic         typed;
    compare_set_t res;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] angle_i;
  logic [14:0] mod_index_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] compare_u_o;
  logic [15:0] compare_v_o;
  logic [15:0] compare_w_o;
  logic        index_limited_o;

  int           sine_rom [ROM_DEPTH];
  logic [15:0]  period_model;
  compare_set_t expected_q [$];
  int           mismatch_count;
  bit           hold_request;

  // Stimulus table; typed rows carry results that follow directly from zero index or zero period
  plan_row_t plan [0:20] = '{
    '{16'h0000, 15'h0000, 16'd65535, 1'b1, '{16'd32767, 16'd32767, 16'd32767, 1'b0}},
    '{16'hFFFF, 15'h0000, 16'd65535, 1'b1, '{16'd32767, 16'd32767, 16'd32767, 1'b0}},
    '{16'h0000, 15'h7FFF, 16'd65535, 1'b0, '0},
    '{16'h4000, 15'd18919, 16'd65535, 1'b0, '0},
    '{16'h4000, 15'd18920, 16'd65535, 1'b0, '0},
    '{16'h5555, 15'h4000, 16'd65535, 1'b0, '0},
    '{16'hAAAA, 15'h2AAA, 16'd65535, 1'b0, '0},
    '{16'h8000, 15'h5555, 16'd65535, 1'b0, '0},
    '{16'hC000, 15'd18919, 16'd65535, 1'b0, '0},
    '{16'h2000, 15'h0001, 16'd65535, 1'b0, '0},
    '{16'h0001, 15'h7FFF, 16'd65535, 1'b0, '0},
    '{16'h0000, 15'h0000, 16'd1, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b0}},
    '{16'h4000, 15'h7FFF, 16'd1, 1'b0, '0},
    '{16'h8000, 15'd18919, 16'd1, 1'b0, '0},
    '{16'h0000, 15'h0000, 16'd0, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b0}},
    '{16'hFFFF, 15'h7FFF, 16'd0, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b1}},
    '{16'h5555, 15'd18919, 16'd0, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b0}},
    '{16'h0000, 15'h0000, 16'd1000, 1'b1, '{16'd500, 16'd500, 16'd500, 1'b0}},
    '{16'hC000, 15'h7FFF, 16'd1000, 1'b0, '0},
    '{16'h0000, 15'h0000, 16'd65535, 1'b1, '{16'd32767, 16'd32767, 16'd32767, 1'b0}},
    '{16'h3FFF, 15'h7FFF, 16'd65535, 1'b0, '0}
  };

  svpwm_angle_to_compare_top #(
    .SINE_TABLE_DEPTH(ROM_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .angle_i        (angle_i),
    .mod_index_i    (mod_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .compare_u_o    (compare_u_o),
    .compare_v_o    (compare_v_o),
    .compare_w_o    (compare_w_o),
    .index_limited_o(index_limited_o)
  );

  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  // (a * b) >> 30 for b >= 0, rounded toward zero
  function automatic longint trunc_q30(longint a, longint b);
    bit [63:0] prod;
    prod = 64'(a < 0 ? -a : a) * 64'(b);
    return (a < 0) ? -longint'(prod >> 30) : longint'(prod >> 30);
  endfunction

  function automatic int sine_point(int k);
    longint x;
    longint x2;
    longint acc;
    longint y;
    longint s;
    int     quad;
    int     rem;
    quad = (4 * k) / ROM_DEPTH;
    rem  = 4 * k - quad * ROM_DEPTH;
    x    = (longint'(rem) <<< 30) / ROM_DEPTH;
    if (quad % 2 == 1) x = ONE_Q30 - x;
    x2  = (x * x) >>> 30;
    acc = TAY9;
    acc = trunc_q30(acc, x2) - TAY7;
    acc = trunc_q30(acc, x2) + TAY5;
    acc = trunc_q30(acc, x2) - TAY3;
    acc = trunc_q30(acc, x2) + TAY1;
    y   = trunc_q30(acc, x);
    if (y < 0) y = 0;
    s = (y + 16384) >>> 15;
    if (s > 32767) s = 32767;
    return (quad >= 2) ? -int'(s) : int'(s);
  endfunction

  function automatic logic [15:0] duty_to_compare(longint p, longint hi, longint lo);
    longint    d;
    bit [63:0] scaled;
    d = ONE_Q30 + 2 * p - hi - lo;
    if (d < 0) d = 0;
    else if (d > 2 * ONE_Q30) d = 2 * ONE_Q30;
    scaled = 64'(d) * 64'(period_model);
    return scaled[46:31];
  endfunction

  function automatic compare_set_t predict_compares(logic [15:0] ang, logic [14:0] mi);
    compare_set_t r;
    longint       m;
    longint       pu;
    longint       pv;
    longint       pw;
    longint       hi;
    longint       lo;
    logic [15:0]  av;
    logic [15:0]  aw;
    r.lim = (int'(mi) > INDEX_CEIL);
    m     = r.lim ? INDEX_CEIL : longint'(mi);
    av    = ang - 16'(THIRD);
    aw    = ang + 16'(THIRD);
    pu    = m * sine_rom[(32'(ang) * ROM_DEPTH) >> 16];
    pv    = m * sine_rom[(32'(av) * ROM_DEPTH) >> 16];
    pw    = m * sine_rom[(32'(aw) * ROM_DEPTH) >> 16];
    hi    = pu;
    if (pv > hi) hi = pv;
    if (pw > hi) hi = pw;
    lo    = pu;
    if (pv < lo) lo = pv;
    if (pw < lo) lo = pw;
    r.u   = duty_to_compare(pu, hi, lo);
    r.v   = duty_to_compare(pv, hi, lo);
    r.w   = duty_to_compare(pw, hi, lo);
    return r;
  endfunction

  // Offer one transfer and hold it until taken, then, when gaps is set, sometimes idle for a random gap
  task automatic send_point(logic [15:0] ang, logic [14:0] mi, compare_set_t want, bit gaps);
    int pick;
    int pause;
    angle_i     <= ang;
    mod_index_i <= mi;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    expected_q.push_back(want);
    pause = 0;
    if (gaps) begin
      pick = $urandom_range(0, 99);
      if (pick >= 92) pause = $urandom_range(10, 30);
      else if (pick >= 50) pause = $urandom_range(1, 3);
    end
    if (pause > 0) begin
      in_valid_i <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_period(logic [15:0] value);
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    period_model = value;
  endtask

  // Result side: random stall runs, calm stretches, and one long hold on request
  initial begin : receiver
    int   run_left;
    int   pick;
    logic level;
    run_left    = 0;
    level       = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_request = 1'b0;
        run_left     = 0;
      end else begin
        if (run_left == 0) begin
          pick = $urandom_range(0, 99);
          if (pick < 10) begin
            level    = 1'b0;
            run_left = $urandom_range(40, 120);
          end else if (pick < 55) begin
            level    = 1'b0;
            run_left = $urandom_range(1, 4);
          end else if (pick < 94) begin
            level    = 1'b1;
            run_left = $urandom_range(1, 3);
          end else begin
            level    = 1'b1;
            run_left = $urandom_range(15, 50);
          end
        end
        out_stall_i <= level;
        run_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    compare_set_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: expected none, got u=%0d v=%0d w=%0d lim=%0b",
                 $time, compare_u_o, compare_v_o, compare_w_o, index_limited_o);
        mismatch_count++;
      end else begin
        want = expected_q.pop_front();
        if (compare_u_o !== want.u) begin
          $display("%0t compare_u: expected %0d, got %0d", $time, want.u, compare_u_o);
          mismatch_count++;
        end
        if (compare_v_o !== want.v) begin
          $display("%0t compare_v: expected %0d, got %0d", $time, want.v, compare_v_o);
          mismatch_count++;
        end
        if (compare_w_o !== want.w) begin
          $display("%0t compare_w: expected %0d, got %0d", $time, want.w, compare_w_o);
          mismatch_count++;
        end
        if (index_limited_o !== want.lim) begin
          $display("%0t index_limited: expected %0b, got %0b", $time, want.lim,
                   index_limited_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCH_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && out_stall_i === 1'b0)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[svpwm_angle_to_compare_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    compare_set_t want;
    logic [15:0]  ang;
    logic [14:0]  mi;
    logic [15:0]  per;
    int           pick;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    angle_i        = '0;
    mod_index_i    = '0;
    mismatch_count = 0;
    hold_request   = 1'b0;
    period_model   = 16'd65535;
    for (int k = 0; k < ROM_DEPTH; k++) sine_rom[k] = sine_point(k);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].per != period_model) begin
        drain_pipe();
        write_period(plan[i].per);
      end
      want = plan[i].typed ? plan[i].res : predict_compares(plan[i].ang, plan[i].mi);
      send_point(plan[i].ang, plan[i].mi, want, 1'b1);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       per = 16'($urandom_range(2, 65534));
        1:       per = 16'd65535;
        2:       per = 16'd1;
        3:       per = 16'($urandom_range(1, 255));
        4:       per = 16'($urandom_range(1, 65535));
        default: per = 16'd32768;
      endcase
      drain_pipe();
      write_period(per);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // fill the pipe against a held output
        if (ph == 3 && n == 40) hold_request = 1'b1;
        // let everything in flight come out before going on
        if (ph == 4 && n == 100) drain_pipe();
        ang  = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25) mi = 15'($urandom_range(INDEX_CEIL + 1, 32767));
        else if (pick < 30) mi = 15'(INDEX_CEIL);
        else if (pick < 34) mi = 15'($urandom_range(0, 1));
        else mi = 15'($urandom_range(0, INDEX_CEIL));
        send_point(ang, mi, predict_compares(ang, mi), ph != 0);
      end
    end

    drain_pipe();
    if (mismatch_count == 0) begin
      $display("[svpwm_angle_to_compare_top] OK");
    end else begin
      $display("[svpwm_angle_to_compare_top] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/svac_pkg.sv
rtl/core/svac_sine_rom.sv
rtl/core/svac_zero_seq.sv
rtl/core/svac_compare.sv
rtl/core/svpwm_angle_to_compare_top.sv
sim/tb.sv
